>>> hw/rtl/clp_pkg.sv
// ----------------------------------------------------------------------------
// clp_pkg
// Shared constants, types and address helpers for the character LCD text
// placer.
// ----------------------------------------------------------------------------
`default_nettype none

package clp_pkg;

    // display geometry
    localparam int COLUMNS = 16;
    localparam int ROWS    = 2;

    localparam int COL_W = 6;
    localparam int ROW_W = 2;

    // bus codes
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CODE_RETURN  = 8'h0D;

    // operations
    localparam logic OP_SET_CURSOR = 1'b0;
    localparam logic OP_PUT_CHAR   = 1'b1;

    // one input request
    typedef struct packed {
        logic             operation;
        logic [COL_W-1:0] start_col;
        logic [2:0]       start_row;
        logic [7:0]       char_code;
    } t_item;

    // one bus write
    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } t_result;

    // ddram offset of each row
    function automatic logic [6:0] row_base(input logic [ROW_W-1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        return base;
    endfunction

    // set-address command for a cursor position
    function automatic logic [7:0] addr_cmd(input logic [COL_W-1:0] col,
                                            input logic [ROW_W-1:0] row);
        logic [6:0] sum;
        sum = 7'({1'b0, col}) + row_base(row);
        return CMD_SET_ADDR | {1'b0, sum};
    endfunction

    // one row down, wrapping to the top row
    function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] row);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + (ROW_W+1)'(1);
        return (sum >= (ROW_W+1)'(ROWS)) ? '0 : sum[ROW_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/clp_in_reg.sv
// ----------------------------------------------------------------------------
// clp_in_reg
// Input register: holds one request until the placer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module clp_in_reg
    import clp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_stall,
    input  wire logic  i_load,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // hold while full and not being drained
    assign o_stall = r_valid && !i_load;
    assign accept  = i_valid && !o_stall;

    // request valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_load) begin
            r_valid <= 1'b0;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> hw/rtl/clp_place.sv
// ----------------------------------------------------------------------------
// clp_place
// Cursor state and the write decode for one request: up to two bus writes.
// ----------------------------------------------------------------------------
`default_nettype none

module clp_place
    import clp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_item i_item,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic [1:0] o_count
);

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic             wrap;
    logic [COL_W-1:0] col1;
    logic [ROW_W-1:0] row1;
    t_result          pre;
    t_result          body;

    // decode one request against the current cursor
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        wrap    = r_col >= COL_W'(COLUMNS);
        col1    = wrap ? '0 : r_col;
        row1    = wrap ? next_row(r_row) : r_row;
        pre     = '{is_data: 1'b0, bus_byte: addr_cmd('0, row1), last: 1'b0};
        body    = '{is_data: 1'b1, bus_byte: i_item.char_code, last: 1'b1};
        o_res0  = body;
        o_res1  = body;
        o_count = 2'd1;

        if (i_item.operation == OP_SET_CURSOR) begin
            n_col = i_item.start_col;
            n_row = (i_item.start_row >= 3'(ROWS)) ? '0 : i_item.start_row[ROW_W-1:0];
            o_res0 = '{is_data: 1'b0, bus_byte: addr_cmd(n_col, n_row), last: 1'b1};
        end else begin
            case (i_item.char_code)
                CODE_NEWLINE: begin
                    n_col = col1;
                    n_row = next_row(row1);
                    body  = '{is_data: 1'b0, bus_byte: addr_cmd(col1, n_row), last: 1'b1};
                end
                CODE_RETURN: begin
                    n_col = '0;
                    n_row = row1;
                    body  = '{is_data: 1'b0, bus_byte: addr_cmd('0, row1), last: 1'b1};
                end
                default: begin
                    n_col = col1 + COL_W'(1);
                    n_row = row1;
                end
            endcase
            if (wrap) begin
                o_res0  = pre;
                o_res1  = body;
                o_count = 2'd2;
            end else begin
                o_res0  = body;
            end
        end
    end

    // cursor update when the request moves to the result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_load) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/clp_out_buf.sv
// ----------------------------------------------------------------------------
// clp_out_buf
// Two-entry buffer for one request's writes; drains one a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module clp_out_buf
    import clp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req,
    input  wire t_result    i_res0,
    input  wire t_result    i_res1,
    input  wire logic [1:0] i_count,
    output logic            o_load,
    input  wire logic       i_stall,
    output logic            o_valid,
    output t_result         o_result
);

    logic [1:0] r_count;
    t_result    r_q0;
    t_result    r_q1;
    logic       take;

    assign o_valid  = r_count != 2'd0;
    assign o_result = r_q0;
    assign take     = o_valid && !i_stall;

    // load only when the buffer is empty after this cycle's pop
    assign o_load = i_req && (r_count == 2'd0 || (r_count == 2'd1 && take));

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (o_load) begin
            r_count <= i_count;
        end else if (take) begin
            r_count <= r_count - 2'd1;
        end
    end

    // entries
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_q0 <= i_res0;
            r_q1 <= i_res1;
        end else if (take) begin
            r_q0 <= r_q1;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/char_lcd_text_placer.sv
// ----------------------------------------------------------------------------
// char_lcd_text_placer
// Turns set-cursor and character requests into HD44780 bus writes.
// ----------------------------------------------------------------------------
// A request is taken into an input register, decoded against the cursor and
// moved into a two-entry result buffer, which puts out one bus write per
// cycle unless the receiver stalls. A request that makes one write (a set
// cursor, a character, a newline or return with no wrap) sustains one
// request per cycle when nothing stalls; a character that first wraps the
// line makes two writes, so the rate is one request per written byte. Set
// cursor rows at or beyond ROWS become row 0; o_last marks the final write
// of each request.
`default_nettype none

module char_lcd_text_placer
    import clp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_operation,
    input  wire logic [COL_W-1:0] i_start_col,
    input  wire logic [2:0]       i_start_row,
    input  wire logic [7:0]       i_char_code,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_is_data,
    output logic [7:0]            o_bus_byte,
    output logic                  o_last
);

    t_item      in_item;
    t_item      req_item;
    logic       req_valid;
    logic       load;
    t_result    res0;
    t_result    res1;
    logic [1:0] res_count;
    t_result    out_res;

    assign in_item = '{operation: i_operation, start_col: i_start_col,
                       start_row: i_start_row, char_code: i_char_code};

    // input register
    clp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .o_stall (o_stall),
        .i_load  (load),
        .o_valid (req_valid),
        .o_item  (req_item)
    );

    // cursor and write decode
    clp_place u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_item  (req_item),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (res_count)
    );

    // result buffer
    clp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req_valid),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_count  (res_count),
        .o_load   (load),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_res)
    );

    assign o_is_data  = out_res.is_data;
    assign o_bus_byte = out_res.bus_byte;
    assign o_last     = out_res.last;

endmodule

`default_nettype wire

>>> hw/rtl/clp_checker.sv
// ----------------------------------------------------------------------------
// clp_checker
// Port-level checks for the character LCD text placer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_is_data,
    input wire logic [7:0] o_bus_byte,
    input wire logic       o_last
);

    // a stalled write holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_is_data)
            && $stable(o_bus_byte) && $stable(o_last))
        else $error("stalled write changed");

    // a data write always ends its request
    a_data_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_data |-> o_last)
        else $error("data write not marked last");

    // every command is a set-address command
    a_cmd_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_data |-> o_bus_byte[7])
        else $error("command without set-address bit");

    // the second write of a pair follows right after the first
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid)
        else $error("gap inside a write pair");

    // reset empties the result side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("write pending after reset");

endmodule

bind char_lcd_text_placer clp_checker u_clp_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks char_lcd_text_placer against a cycle-free model of its cursor and
// bus writes. Directed requests hit the column and row extremes, row
// clamping, line wrap, newline and carriage return; random traffic follows
// under four phases of sender idling and receiver stall.
// ----------------------------------------------------------------------------

module testbench;
    import clp_pkg::*;

    localparam int ITEMS_PER_PHASE = 137;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;

    // expected bus writes, built from a private copy of the cursor
    class lcd_write_scoreboard;
        t_result    pending[$];
        logic [5:0] cur_col;
        int         cur_row;
        int         mismatches;
        int         writes_seen;

        function new();
            cur_col     = '0;
            cur_row     = 0;
            mismatches  = 0;
            writes_seen = 0;
        endfunction

        function logic [6:0] row_offset(int row);
            case (row)
                0:       return 7'h00;
                1:       return 7'h40;
                2:       return 7'h14;
                default: return 7'h54;
            endcase
        endfunction

        // move the cursor, clamping the row, and form the address command
        function t_result addr_write(logic [5:0] col, int row);
            t_result    w;
            logic [6:0] sum;
            cur_col    = col;
            cur_row    = (row >= ROWS) ? 0 : row;
            sum        = 7'(col) + row_offset(cur_row);
            w.is_data  = 1'b0;
            w.bus_byte = CMD_SET_ADDR | {1'b0, sum};
            w.last     = 1'b0;
            return w;
        endfunction

        // accepted request: work out the writes it causes
        function void note_request(t_item req);
            t_result batch[$];
            t_result w;
            if (req.operation == OP_SET_CURSOR) begin
                batch.push_back(addr_write(req.start_col, int'(req.start_row)));
            end else begin
                // full line wraps to the next row first
                if (cur_col >= COLUMNS)
                    batch.push_back(addr_write('0, cur_row + 1));
                if (req.char_code == CODE_NEWLINE) begin
                    batch.push_back(addr_write(cur_col, cur_row + 1));
                end else if (req.char_code == CODE_RETURN) begin
                    batch.push_back(addr_write('0, cur_row));
                end else begin
                    w.is_data  = 1'b1;
                    w.bus_byte = req.char_code;
                    w.last     = 1'b0;
                    batch.push_back(w);
                    cur_col = cur_col + 6'd1;
                end
            end
            batch[batch.size()-1].last = 1'b1;
            foreach (batch[k])
                pending.push_back(batch[k]);
        endfunction

        // accepted write: compare with the oldest expectation
        function void check_write(t_result got);
            t_result want;
            writes_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected write: is_data=%0b byte=%02h last=%0b",
                             got.is_data, got.bus_byte, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.is_data !== want.is_data || got.bus_byte !== want.bus_byte ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("write %0d mismatch: is_data %0b/%0b byte %02h/%02h last %0b/%0b",
                             writes_seen, want.is_data, got.is_data, want.bus_byte,
                             got.bus_byte, want.last, got.last);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic             i_operation;
    logic [COL_W-1:0] i_start_col;
    logic [2:0]       i_start_row;
    logic [7:0]       i_char_code;
    logic             o_valid;
    logic             i_stall;
    logic             o_is_data;
    logic [7:0]       o_bus_byte;
    logic             o_last;

    lcd_write_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int cycle_count;
    int requests_sent;
    int set_cursor_sent;

    char_lcd_text_placer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_start_col (i_start_col),
        .i_start_row (i_start_row),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_is_data   (o_is_data),
        .o_bus_byte  (o_bus_byte),
        .o_last      (o_last)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // write monitor
    always @(posedge i_clk) begin : write_monitor
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.is_data  = o_is_data;
            got.bus_byte = o_bus_byte;
            got.last     = o_last;
            sb.check_write(got);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // drive one request, with random idle cycles ahead of it
    task automatic send_request(logic op, logic [5:0] col, logic [2:0] row,
                                logic [7:0] code);
        t_item req;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        req.operation = op;
        req.start_col = col;
        req.start_row = row;
        req.char_code = code;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_start_col <= col;
        i_start_row <= row;
        i_char_code <= code;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_request(req);
        requests_sent++;
        if (op == OP_SET_CURSOR)
            set_cursor_sent++;
    endtask

    // random request, mostly characters with frequent line control
    task automatic send_random_request();
        int         pick;
        logic [5:0] col;
        logic [7:0] code;
        pick = $urandom_range(0, 99);
        col  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, COLUMNS - 1));
        if (pick < 12)
            code = CODE_NEWLINE;
        else if (pick < 22)
            code = CODE_RETURN;
        else
            code = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 15)
            send_request(OP_SET_CURSOR, col, 3'($urandom_range(0, 7)), code);
        else
            send_request(OP_PUT_CHAR, col, 3'($urandom_range(0, 7)), code);
    endtask

    initial begin
        sb              = new();
        send_idle_pct   = 0;
        stall_pct       = 0;
        cycle_count     = 0;
        requests_sent   = 0;
        set_cursor_sent = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_stall     <= 1'b0;
        i_operation <= OP_SET_CURSOR;
        i_start_col <= '0;
        i_start_row <= '0;
        i_char_code <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, row clamp, wrap ahead of data, newline, return
        send_request(OP_SET_CURSOR, 6'd63, 3'd7, 8'hFF);
        send_request(OP_PUT_CHAR,   6'd63, 3'd7, 8'h00);
        send_request(OP_SET_CURSOR, 6'd0,  3'd1, 8'h00);
        send_request(OP_PUT_CHAR,   6'd0,  3'd0, 8'hFF);
        send_request(OP_SET_CURSOR, 6'd15, 3'd1, 8'h41);
        send_request(OP_PUT_CHAR,   6'd21, 3'd5, 8'h41);
        send_request(OP_PUT_CHAR,   6'd0,  3'd0, CODE_NEWLINE);
        send_request(OP_SET_CURSOR, 6'd15, 3'd0, 8'h00);
        send_request(OP_PUT_CHAR,   6'd42, 3'd2, 8'h55);
        send_request(OP_PUT_CHAR,   6'd0,  3'd0, CODE_RETURN);
        send_request(OP_SET_CURSOR, 6'd16, 3'd0, 8'h00);
        send_request(OP_PUT_CHAR,   6'd0,  3'd0, 8'hAA);
        send_request(OP_PUT_CHAR,   6'd0,  3'd0, CODE_NEWLINE);
        send_request(OP_PUT_CHAR,   6'd0,  3'd0, CODE_RETURN);
        send_request(OP_SET_CURSOR, 6'd63, 3'd1, 8'h00);
        send_request(OP_SET_CURSOR, 6'd5,  3'd2, 8'h00);
        send_request(OP_SET_CURSOR, 6'd0,  3'd3, 8'h00);
        send_request(OP_SET_CURSOR, 6'd7,  3'd4, 8'h00);
        send_request(OP_PUT_CHAR,   6'd0,  3'd0, 8'h7F);
        send_request(OP_PUT_CHAR,   6'd0,  3'd0, 8'h80);

        // random traffic under four idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 77; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 7;  stall_pct = 7;  end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_request();
            // after the first phase the sender holds off until the block has drained
            if (phase == 0) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending.size() != 0)
                    @(posedge i_clk);
            end
        end

        // drain
        i_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests (%0d set cursor) and %0d bus writes",
                 requests_sent, set_cursor_sent, sb.writes_seen);
        $display("phases: no idling, sender gaps, receiver stalls, light mix");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches, %0d writes missing", sb.mismatches,
                     sb.pending.size());
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
